// ----- src/sps_pkg.sv -----
// shared types and constants for the sorted position set
// no dependencies; imported by every module of the block

package sps_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_UPD
   } sps_state_type;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   localparam int REQ_DATA_BITS = 16;
   localparam int RSP_DATA_BITS = 24;
   localparam int FIELD_BITS    = 9;

   typedef struct packed {
      logic compare;
      logic insert;
   } sps_ctrl_type;

endpackage

// ----- src/sps_cell.sv -----
// one cell of the sorted chain: holds one key, compares it against the
// broadcast key and shifts in its lower neighbor's key on insert; uses sps_pkg

module sps_cell #(
   parameter int KEY_BITS = 16
) (
   input  logic                 clock,
   input  sps_pkg::sps_ctrl_type ctrl,
   input  logic [KEY_BITS-1:0]  key,
   input  logic                 valid,
   input  logic [KEY_BITS-1:0]  prev_entry,
   input  logic                 prev_less,
   output logic [KEY_BITS-1:0]  entry,
   output logic                 less,
   output logic                 equal,
   output logic                 boundary
);
   import sps_pkg::*;

   logic [KEY_BITS-1:0] entry_ff, entry_in;
   logic                less_ff, less_in;
   logic                equal_ff, equal_in;

   always_comb begin
      less_in  = less_ff;
      equal_in = equal_ff;
      entry_in = entry_ff;
      if (ctrl.compare) begin
         less_in  = valid && (entry_ff < key);
         equal_in = valid && (entry_ff == key);
      end
      if (ctrl.insert && !less_ff) begin
         entry_in = boundary ? key : prev_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      less_ff  <= less_in;
      equal_ff <= equal_in;
   end

   assign boundary = !less_ff && prev_less;
   assign entry    = entry_ff;
   assign less     = less_ff;
   assign equal    = equal_ff;

endmodule

// ----- src/sorted_position_set.sv -----
// channel | ports                    | tdata / tuser
// req     | req_tvalid/tready/tdata  | tuser: cmd; tdata: position
// rsp     | rsp_tvalid/tready/tdata  | tdata: present, slot_index, entry_count, dropped_full
//
// an item passes through ST_CMP, which registers every cell's compare, then ST_UPD,
// which encodes the slot, shifts the chain and loads the result register
// a new item is taken in the update cycle of the previous one
// reset clears the entry count, the state and the result valid flag; cell keys are not cleared
// a stalled result holds the update cycle until the result register frees up
// uses sps_pkg and sps_cell

module sorted_position_set #(
   parameter int CAPACITY = 256,
   parameter int KEY_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sps_pkg::REQ_DATA_BITS-1:0] req_tdata,  // position[15:0]
   input  logic                              req_tuser,  // cmd
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // present[0], slot_index[9:1], entry_count[18:10], dropped_full[19], zero[23:20]
   output logic [sps_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import sps_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   sps_state_type state_ff, state_in;
   sps_ctrl_type  ctrl;

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic                cmd_ff, cmd_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic [KEY_BITS-1:0] entry_w [CAPACITY];
   logic [CAPACITY-1:0] less_w, equal_w, bnd_w;

   logic          req_xfer, can_load, present, full, do_insert, any_bnd;
   logic [CW-1:0] enc, slot;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic [KEY_BITS-1:0] prev_entry;
         logic                prev_less;
         if (gi == 0) begin : g_head
            assign prev_entry = key_ff;
            assign prev_less  = 1'b1;
         end else begin : g_link
            assign prev_entry = entry_w[gi-1];
            assign prev_less  = less_w[gi-1];
         end
         sps_cell #(.KEY_BITS(KEY_BITS)) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .key        (key_ff),
            .valid      (CW'(gi) < count_ff),
            .prev_entry (prev_entry),
            .prev_less  (prev_less),
            .entry      (entry_w[gi]),
            .less       (less_w[gi]),
            .equal      (equal_w[gi]),
            .boundary   (bnd_w[gi])
         );
      end
   endgenerate

   always_comb begin
      enc = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (bnd_w[i]) begin
            enc = enc | CW'(i);
         end
      end
   end

   assign any_bnd   = |bnd_w;
   assign slot      = any_bnd ? enc : count_ff;
   assign present   = |equal_w;
   assign full      = (count_ff == CW'(CAPACITY));
   assign do_insert = (cmd_ff == CMD_INSERT) && !present && !full;
   assign can_load  = !rsp_valid_ff || rsp_tready;
   assign req_xfer  = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      ctrl         = '0;
      req_tready   = 1'b0;
      key_in       = key_ff;
      cmd_in       = cmd_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_CMP: begin
            ctrl.compare = 1'b1;
            state_in     = ST_UPD;
         end
         ST_UPD: begin
            if (can_load) begin
               req_tready   = 1'b1;
               ctrl.insert  = do_insert;
               count_in     = do_insert ? count_ff + CW'(1) : count_ff;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[0]     = present;
               rsp_data_in[9:1]   = FIELD_BITS'(slot);
               rsp_data_in[18:10] = FIELD_BITS'(count_in);
               rsp_data_in[19]    = (cmd_ff == CMD_INSERT) && !present && full;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (req_xfer) begin
         key_in   = KEY_BITS'(req_tdata);
         cmd_in   = req_tuser;
         state_in = ST_CMP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      cmd_ff      <= cmd_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- src/sps_checker.sv -----
// port-level checks for sorted_position_set, bound to the top level
// uses sps_pkg

module sps_checker #(
   parameter int CAPACITY = 256
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [sps_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input logic                              req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [sps_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import sps_pkg::*;

   localparam logic [FIELD_BITS-1:0] CAP_FIELD = FIELD_BITS'(CAPACITY);

   logic                  present, dropped;
   logic [FIELD_BITS-1:0] slot, count;

   assign present = rsp_tdata[0];
   assign slot    = rsp_tdata[9:1];
   assign count   = rsp_tdata[18:10];
   assign dropped = rsp_tdata[19];

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable({req_tuser, req_tdata}))
      else $error("request dropped or changed while waiting");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && dropped |-> !present && count == CAP_FIELD)
      else $error("drop flagged while not full or key present");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (CAPACITY > 511) || (slot <= count && count <= CAP_FIELD))
      else $error("slot or count out of range");

endmodule

bind sorted_position_set sps_checker #(.CAPACITY(CAPACITY)) u_sps_checker (.*);
